/* design/sharded_clock_replacer_top_assert.svh */
// assertion macros for the sharded clock replacer
// no dependencies; taken in by the files that carry concurrent checks
`ifndef SHARDED_CLOCK_REPLACER_TOP_ASSERT_SVH
`define SHARDED_CLOCK_REPLACER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SCR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("scr check failed");
`define SCR_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("scr check failed");
`else
`define SCR_ASSERT(lbl, clk, rst, prop)
`define SCR_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* design/scr_pkg.sv */
// shared types and constants of the sharded clock replacer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

  localparam int FRAME_W  = 10;
  localparam int ACTION_W = 2;
  localparam int TOTAL_W  = 11;

  // action codes of an input word
  typedef enum logic [ACTION_W-1:0] {
    ACT_PIN    = 2'd0,
    ACT_UNPIN  = 2'd1,
    ACT_VICTIM = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage

`default_nettype wire

/* design/scr_ram.sv */
// simple dual-port synchronous memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module scr_ram #(
  parameter int WIDTH = 2,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:(2**AW)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/scr_locate.sv */
// splits a frame number into shard and slot by constant reciprocal multiplication
// depends on scr_pkg; result registered through stage one and stage two after load, held until next load
`timescale 1ns / 1ps
`default_nettype none

module scr_locate #(
  parameter int SHARDS = 8,
  parameter int SLOTS  = 128,
  parameter int SW     = 3,
  parameter int LW     = 7
) (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [scr_pkg::FRAME_W-1:0] frame_number,
  output logic      [SW-1:0]               shard,
  output logic      [LW-1:0]               slot
);
  import scr_pkg::*;

  // reciprocal scaled by 2^(N+l) is exact for every N-bit numerator
  localparam int K1 = FRAME_W + $clog2(SHARDS);
  localparam int K2 = FRAME_W + $clog2(SLOTS);
  localparam int MW = FRAME_W + 2;
  localparam int PW = FRAME_W + MW;
  localparam longint unsigned M1 =
    ((64'd1 << K1) + 64'(SHARDS) - 64'd1) / 64'(SHARDS);
  localparam longint unsigned M2 =
    ((64'd1 << K2) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  logic [FRAME_W-1:0] f1;
  logic [FRAME_W-1:0] q1;
  logic [FRAME_W-1:0] q1b;
  logic [FRAME_W-1:0] q2;
  logic [SW-1:0]      shard_q;
  logic [PW-1:0]      p1;
  logic [PW-1:0]      p2;

  // stage one: quotient by shard count
  assign p1 = PW'(frame_number) * PW'(MW'(M1));

  always_ff @(posedge clk) begin
    if (load) begin
      f1 <= frame_number;
      q1 <= FRAME_W'(p1 >> K1);
    end
  end

  // stage two: shard remainder and quotient by slot count
  assign p2 = PW'(q1) * PW'(MW'(M2));

  always_ff @(posedge clk) begin
    shard_q <= SW'(32'(f1) - 32'(q1) * 32'(SHARDS));
    q1b     <= q1;
    q2      <= FRAME_W'(p2 >> K2);
  end

  // slot wraps modulo the shard size
  assign shard = shard_q;
  assign slot  = LW'(32'(q1b) - 32'(q2) * 32'(SLOTS));

endmodule

`default_nettype wire

/* design/sharded_clock_replacer_top.sv */
// top level of the sharded clock replacer: control sequencer around two memories
// depends on scr_pkg, scr_locate, scr_ram and sharded_clock_replacer_top_assert.svh
//
// Usage
//   Input words carry action (pin, unpin, victim request) and frame_number on a
//   valid/ready channel; each word yields exactly one output word on a
//   valid/ready channel with victim_found, victim_frame and evictable_total.
//   Reference and present bits live in a 2-bit wide slot memory addressed by
//   {shard, slot}; each shard's hand and count live in a shard table memory.
//   After accept, pin and unpin pass through locate, read, write back and
//   result; an unused action code goes straight to result; a victim request
//   reads the table entry of each shard visited and examines its slots in
//   turn, bounded by two rounds of all shards. One word is worked on at a time
//   and the input reopens the cycle after the result is loaded, so a new word
//   is taken only once the last is through; the read-modify-write sweep handles one slot per cycle.
//   The next word is accepted while a result waits in the output register; a
//   stalled receiver holds the block only when the next result is ready.
//   Reset starts a clearing pass over the slot memory and the shard table,
//   during which no input word is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "sharded_clock_replacer_top_assert.svh"

module sharded_clock_replacer_top #(
  parameter int SHARDS = 8,
  parameter int FRAMES = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [scr_pkg::ACTION_W-1:0] action,
  input  wire logic [scr_pkg::FRAME_W-1:0]  frame_number,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              victim_found,
  output logic      [scr_pkg::FRAME_W-1:0]  victim_frame,
  output logic      [scr_pkg::TOTAL_W-1:0]  evictable_total
);
  import scr_pkg::*;

  localparam int SLOTS = (FRAMES + SHARDS - 1) / SHARDS;
  localparam int SW    = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int LW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int AW    = SW + LW;
  localparam int TW    = LW + CW;

  localparam logic [SW-1:0] LAST_SHARD = SW'(SHARDS - 1);
  localparam logic [LW-1:0] LAST_SLOT  = LW'(SLOTS - 1);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_LOC    = 9'b000000100,
    ST_RD     = 9'b000001000,
    ST_MOD    = 9'b000010000,
    ST_VRD    = 9'b000100000,
    ST_VCHK   = 9'b001000000,
    ST_VSWEEP = 9'b010000000,
    ST_RESP   = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  action_t            act, act_next;
  logic [SW-1:0]      cur_shard, cur_shard_next;
  logic               round, round_next;
  logic [LW-1:0]      hand, hand_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [LW-1:0]      step, step_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic               res_found, res_found_next;
  logic [FRAME_W-1:0] res_frame, res_frame_next;
  logic               out_load;

  // memory ports
  logic          slot_we, slot_re;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [1:0]    slot_wdata, slot_rdata;
  logic          tab_we, tab_re;
  logic [SW-1:0] tab_waddr, tab_raddr;
  logic [TW-1:0] tab_wdata, tab_rdata;
  logic [LW-1:0] tab_hand;
  logic [CW-1:0] tab_cnt;

  // locate results
  logic [SW-1:0] lc_shard;
  logic [LW-1:0] lc_slot;

  // sweep helpers
  logic [LW-1:0] hand_inc;
  state_t        adv_state;
  logic [SW-1:0] adv_shard;
  logic          adv_round;

  scr_locate #(
    .SHARDS (SHARDS),
    .SLOTS  (SLOTS),
    .SW     (SW),
    .LW     (LW)
  ) u_locate (
    .clk          (clk),
    .load         (in_valid && in_ready),
    .frame_number (frame_number),
    .shard        (lc_shard),
    .slot         (lc_slot)
  );

  scr_ram #(
    .WIDTH (2),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  scr_ram #(
    .WIDTH (TW),
    .AW    (SW)
  ) u_shard_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  assign tab_hand = tab_rdata[TW-1:CW];
  assign tab_cnt  = tab_rdata[CW-1:0];
  assign in_ready = (state == ST_IDLE);
  assign hand_inc = (hand == LAST_SLOT) ? '0 : hand + LW'(1);
  assign out_load = (state == ST_RESP) && (!out_valid || out_ready);

  // move on to the next shard, ending after the second round
  always_comb begin
    adv_round = round;
    if (cur_shard == LAST_SHARD) begin
      adv_shard = '0;
      adv_round = 1'b1;
      adv_state = round ? ST_RESP : ST_VRD;
    end else begin
      adv_shard = cur_shard + SW'(1);
      adv_state = ST_VRD;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    act_next       = act;
    cur_shard_next = cur_shard;
    round_next     = round;
    hand_next      = hand;
    cnt_next       = cnt;
    step_next      = step;
    total_next     = total;
    res_found_next = res_found;
    res_frame_next = res_frame;
    slot_we        = 1'b0;
    slot_waddr     = {cur_shard, hand};
    slot_wdata     = 2'b00;
    slot_re        = 1'b0;
    slot_raddr     = {lc_shard, lc_slot};
    tab_we         = 1'b0;
    tab_waddr      = cur_shard;
    tab_wdata      = {hand_inc, cnt};
    tab_re         = 1'b0;
    tab_raddr      = cur_shard;
    case (state)
      ST_CLEAR: begin
        slot_we       = 1'b1;
        slot_waddr    = clr_addr;
        tab_we        = 1'b1;
        tab_waddr     = clr_addr[SW-1:0];
        tab_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          act_next       = action_t'(action);
          res_found_next = 1'b0;
          res_frame_next = '0;
          cur_shard_next = '0;
          round_next     = 1'b0;
          case (action_t'(action))
            ACT_PIN, ACT_UNPIN: state_next = ST_LOC;
            ACT_VICTIM:         state_next = ST_VRD;
            default:            state_next = ST_RESP;
          endcase
        end
      end
      ST_LOC: begin
        state_next = ST_RD;
      end
      ST_RD: begin
        slot_re    = 1'b1;
        slot_raddr = {lc_shard, lc_slot};
        tab_re     = 1'b1;
        tab_raddr  = lc_shard;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        slot_waddr = {lc_shard, lc_slot};
        tab_waddr  = lc_shard;
        if (act == ACT_PIN && slot_rdata[1]) begin
          slot_we    = 1'b1;
          slot_wdata = 2'b00;
          tab_we     = 1'b1;
          tab_wdata  = {tab_hand, tab_cnt - CW'(1)};
          total_next = total - TOTAL_W'(1);
        end else if (act == ACT_UNPIN && !slot_rdata[1]) begin
          slot_we    = 1'b1;
          slot_wdata = 2'b11;
          tab_we     = 1'b1;
          tab_wdata  = {tab_hand, tab_cnt + CW'(1)};
          total_next = total + TOTAL_W'(1);
        end
        state_next = ST_RESP;
      end
      ST_VRD: begin
        tab_re     = 1'b1;
        tab_raddr  = cur_shard;
        state_next = ST_VCHK;
      end
      ST_VCHK: begin
        hand_next = tab_hand;
        cnt_next  = tab_cnt;
        step_next = '0;
        if (tab_cnt == '0) begin
          cur_shard_next = adv_shard;
          round_next     = adv_round;
          state_next     = adv_state;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = {cur_shard, tab_hand};
          state_next = ST_VSWEEP;
        end
      end
      ST_VSWEEP: begin
        if (slot_rdata[1] && !slot_rdata[0]) begin
          // evict: clear the slot, step the hand past it
          slot_we        = 1'b1;
          slot_wdata     = 2'b00;
          tab_we         = 1'b1;
          tab_wdata      = {hand_inc, cnt - CW'(1)};
          total_next     = total - TOTAL_W'(1);
          res_found_next = 1'b1;
          res_frame_next = FRAME_W'(32'(hand) * 32'(SHARDS) + 32'(cur_shard));
          state_next     = ST_RESP;
        end else begin
          // second chance: drop the reference bit
          if (slot_rdata[1]) begin
            slot_we    = 1'b1;
            slot_wdata = 2'b10;
          end
          hand_next = hand_inc;
          step_next = step + LW'(1);
          if (step == LAST_SLOT) begin
            tab_we         = 1'b1;
            tab_wdata      = {hand_inc, cnt};
            cur_shard_next = adv_shard;
            round_next     = adv_round;
            state_next     = adv_state;
          end else begin
            slot_re    = 1'b1;
            slot_raddr = {cur_shard, hand_inc};
          end
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      total    <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      total    <= total_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    act       <= act_next;
    cur_shard <= cur_shard_next;
    round     <= round_next;
    hand      <= hand_next;
    cnt       <= cnt_next;
    step      <= step_next;
    res_found <= res_found_next;
    res_frame <= res_frame_next;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      victim_found    <= res_found;
      victim_frame    <= res_frame;
      evictable_total <= total;
    end
  end

  // checks
  `SCR_NEVER(a_rw_same_slot, clk, rst, slot_we && slot_re && (slot_waddr == slot_raddr))
  `SCR_ASSERT(a_pin_count, clk, rst, (state == ST_MOD && act == ACT_PIN && slot_rdata[1]) |-> (tab_cnt != '0))
  `SCR_ASSERT(a_found_victim, clk, rst, (state == ST_RESP && res_found) |-> (act == ACT_VICTIM))
  `SCR_ASSERT(a_out_from_resp, clk, rst, $rose(out_valid) |-> $past(state == ST_RESP))

endmodule

`default_nettype wire
